### hdl/cfv_pkg.sv
// Shared types and constants for the COBS frame receiver and validator.
package cfv_pkg;

  localparam int unsigned HeaderLen = 8;

  localparam logic [7:0] Delimiter = 8'h00;
  localparam logic [7:0] CodeMax   = 8'hFF;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] CfgMaxPayload = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgMaxName    = 2'd1;

  localparam logic [15:0] MaxPayloadReset = 16'd256;
  localparam logic [7:0]  MaxNameReset    = 8'd64;

  typedef enum logic [0:0] {
    ACT_BYTE    = 1'b0,
    ACT_OVERRUN = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    RGN_HEADER  = 2'd0,
    RGN_PAYLOAD = 2'd1,
    RGN_NAME    = 2'd2
  } region_e;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_COBS_TRUNC   = 4'd1,
    ST_SHORT        = 4'd2,
    ST_BAD_PAYLOAD  = 4'd3,
    ST_BAD_NAME     = 4'd4,
    ST_MISMATCH     = 4'd5,
    ST_UNTERMINATED = 4'd6,
    ST_TOO_LARGE    = 4'd7,
    ST_OVERRUN      = 4'd8
  } status_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  decoded_byte;
    region_e     region;
    status_e     frame_status;
    logic [31:0] payload_size;
    logic [31:0] name_length;
  } result_t;

endpackage

### hdl/cfv_in_reg.sv
// Input register: holds one received word until the decoder takes it.
module cfv_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  cfv_pkg::item_t in_item_i,
  output logic          in_ready_o,
  input  logic          advance_i,
  output logic          valid_o,
  output cfv_pkg::item_t item_o
);
  import cfv_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hdl/cfv_decoder.sv
// COBS decode state, region tagging and end-of-frame checks.
module cfv_decoder #(
  parameter int unsigned FrameCapacity = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  cfv_pkg::item_t   item_i,
  input  logic [15:0]      max_payload_size_i,
  input  logic [7:0]       max_name_size_i,
  output logic             has_result_o,
  output cfv_pkg::result_t result_o
);
  import cfv_pkg::*;

  localparam int unsigned CntW = $clog2(FrameCapacity + 1);
  localparam logic [CntW-1:0] Capacity = CntW'(FrameCapacity);

  logic            dropping_q, dropping_d;
  logic [CntW-1:0] enc_cnt_q, enc_cnt_d;
  logic [7:0]      grp_rem_q, grp_rem_d;
  logic            zero_pend_q, zero_pend_d;
  logic [CntW-1:0] dec_cnt_q, dec_cnt_d;
  logic [63:0]     hdr_q, hdr_d;
  logic            last_zero_q, last_zero_d;

  logic        emit;
  logic [7:0]  emit_byte;
  logic [63:0] hdr_upd;
  region_e     emit_region;
  status_e     judge;
  logic [31:0] ps, nl;
  logic        frame_open;

  assign ps         = hdr_q[31:0];
  assign nl         = hdr_q[63:32];
  assign frame_open = !dropping_q && (enc_cnt_q != '0);

  // Checks at the delimiter; the length sum only matters once both sizes
  // are within their limits, so 18 bits hold it.
  always_comb begin
    if (grp_rem_q != 8'd0) begin
      judge = ST_COBS_TRUNC;
    end else if (dec_cnt_q < CntW'(HeaderLen)) begin
      judge = ST_SHORT;
    end else if (ps == 32'd0 || ps > {16'd0, max_payload_size_i}) begin
      judge = ST_BAD_PAYLOAD;
    end else if (nl == 32'd0 || nl > {24'd0, max_name_size_i}) begin
      judge = ST_BAD_NAME;
    end else if (18'(dec_cnt_q) != 18'(HeaderLen) + 18'(ps[15:0]) + 18'(nl[7:0])) begin
      judge = ST_MISMATCH;
    end else if (!last_zero_q) begin
      judge = ST_UNTERMINATED;
    end else begin
      judge = ST_OK;
    end
  end

  // Region of the byte at the current decoded position, header after update.
  always_comb begin
    hdr_upd = hdr_q;
    if (dec_cnt_q < CntW'(HeaderLen)) begin
      hdr_upd[{dec_cnt_q[2:0], 3'b000} +: 8] = emit_byte;
      emit_region = RGN_HEADER;
    end else if ((32'(dec_cnt_q) - 32'(HeaderLen)) < ps) begin
      emit_region = RGN_PAYLOAD;
    end else begin
      emit_region = RGN_NAME;
    end
  end

  always_comb begin
    dropping_d  = dropping_q;
    enc_cnt_d   = enc_cnt_q;
    grp_rem_d   = grp_rem_q;
    zero_pend_d = zero_pend_q;
    dec_cnt_d   = dec_cnt_q;
    hdr_d       = hdr_q;
    last_zero_d = last_zero_q;
    emit        = 1'b0;
    emit_byte   = 8'd0;

    has_result_o          = 1'b0;
    result_o.is_verdict   = 1'b1;
    result_o.decoded_byte = 8'd0;
    result_o.region       = RGN_HEADER;
    result_o.frame_status = ST_OK;
    result_o.payload_size = hdr_q[31:0];
    result_o.name_length  = hdr_q[63:32];

    priority if (item_i.action == ACT_OVERRUN) begin
      has_result_o          = frame_open;
      result_o.frame_status = ST_OVERRUN;
      dropping_d            = 1'b1;
    end else if (item_i.rx_byte == Delimiter) begin
      has_result_o          = frame_open;
      result_o.frame_status = judge;
      dropping_d            = 1'b0;
    end else if (dropping_q) begin
      has_result_o = 1'b0;
    end else if (enc_cnt_q >= Capacity) begin
      has_result_o          = 1'b1;
      result_o.frame_status = ST_TOO_LARGE;
      dropping_d            = 1'b1;
    end else begin
      enc_cnt_d = enc_cnt_q + 1'b1;
      if (grp_rem_q == 8'd0) begin
        // code byte: release the implied zero of the previous group
        emit        = zero_pend_q;
        emit_byte   = 8'd0;
        grp_rem_d   = item_i.rx_byte - 8'd1;
        zero_pend_d = (item_i.rx_byte != CodeMax);
      end else begin
        emit      = 1'b1;
        emit_byte = item_i.rx_byte;
        grp_rem_d = grp_rem_q - 8'd1;
      end
    end

    if (emit) begin
      has_result_o          = 1'b1;
      result_o.is_verdict   = 1'b0;
      result_o.decoded_byte = emit_byte;
      result_o.region       = emit_region;
      result_o.payload_size = hdr_upd[31:0];
      result_o.name_length  = hdr_upd[63:32];
      hdr_d                 = hdr_upd;
      dec_cnt_d             = dec_cnt_q + 1'b1;
      last_zero_d           = (emit_byte == 8'd0);
    end

    // any verdict or drop start closes the frame
    if (item_i.action == ACT_OVERRUN || item_i.rx_byte == Delimiter ||
        (!dropping_q && enc_cnt_q >= Capacity)) begin
      enc_cnt_d   = '0;
      grp_rem_d   = 8'd0;
      zero_pend_d = 1'b0;
      dec_cnt_d   = '0;
      hdr_d       = 64'd0;
      last_zero_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dropping_q  <= 1'b0;
      enc_cnt_q   <= '0;
      grp_rem_q   <= 8'd0;
      zero_pend_q <= 1'b0;
      dec_cnt_q   <= '0;
      hdr_q       <= 64'd0;
      last_zero_q <= 1'b0;
    end else if (advance_i) begin
      dropping_q  <= dropping_d;
      enc_cnt_q   <= enc_cnt_d;
      grp_rem_q   <= grp_rem_d;
      zero_pend_q <= zero_pend_d;
      dec_cnt_q   <= dec_cnt_d;
      hdr_q       <= hdr_d;
      last_zero_q <= last_zero_d;
    end
  end

endmodule

### hdl/cfv_out_reg.sv
// Result register: holds one result word until the receiver takes it.
module cfv_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cfv_pkg::result_t result_i,
  input  logic             ready_i,
  output logic             valid_o,
  output cfv_pkg::result_t result_o
);
  import cfv_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### hdl/cobs_frame_receiver_validator.sv
// Top level of the COBS frame receiver and validator.
//
// Input channel (in_valid_i/in_ready_o): one word per received UART byte
// (action_i = 0) or per receive overrun event (action_i = 1). Bytes between
// 0x00 delimiters are COBS-decoded; each decoded byte leaves on the output
// channel (out_valid_o/out_ready_i) tagged with its region, and a delimiter
// closing a non-empty frame yields one verdict word with frame_status_o.
// Oversized frames, and overruns within an open frame, give an immediate verdict;
// both start dropping bytes up to the next delimiter.
// A word lands in the input register when it is accepted, and its result moves
// on into the result register, which raises out_valid_o. Throughput: one word
// per cycle while the receiver keeps taking results; the decode state updates
// once per word.
// The limit registers are written through cfg_we_i/cfg_index_i/cfg_wdata_i;
// the user must write them only while the block is idle, which it does not enforce.
// Reset clears both registers' valid flags and the decode state, and loads
// max payload 256 and max name 64.
// When the receiver stalls, the result register holds its word; the input
// register keeps taking words that yield no result, and fills after one more.
module cobs_frame_receiver_validator #(
  parameter int unsigned FRAME_CAPACITY = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              is_verdict_o,
  output logic [7:0]                        decoded_byte_o,
  output logic [1:0]                        region_o,
  output logic [3:0]                        frame_status_o,
  output logic [31:0]                       payload_size_o,
  output logic [31:0]                       name_length_o,
  input  logic                              cfg_we_i,
  input  logic [cfv_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [cfv_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import cfv_pkg::*;

  logic [15:0] max_payload_q;
  logic [7:0]  max_name_q;

  item_t   in_item;
  item_t   s_item;
  logic    s_valid;
  logic    advance;
  logic    has_result;
  result_t dec_result;
  result_t out_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
      max_name_q    <= MaxNameReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgMaxPayload) begin
        max_payload_q <= cfg_wdata_i;
      end else if (cfg_index_i == CfgMaxName) begin
        max_name_q <= cfg_wdata_i[7:0];
      end
    end
  end

  assign in_item.action  = action_e'(action_i);
  assign in_item.rx_byte = rx_byte_i;

  // advance when the word yields nothing or the result register frees up
  assign advance = s_valid && (!has_result || !out_valid_o || out_ready_i);

  cfv_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item),
    .in_ready_o (in_ready_o),
    .advance_i  (advance),
    .valid_o    (s_valid),
    .item_o     (s_item)
  );

  cfv_decoder #(
    .FrameCapacity (FRAME_CAPACITY)
  ) u_decoder (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .advance_i          (advance),
    .item_i             (s_item),
    .max_payload_size_i (max_payload_q),
    .max_name_size_i    (max_name_q),
    .has_result_o       (has_result),
    .result_o           (dec_result)
  );

  cfv_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && has_result),
    .result_i (dec_result),
    .ready_i  (out_ready_i),
    .valid_o  (out_valid_o),
    .result_o (out_result)
  );

  assign is_verdict_o   = out_result.is_verdict;
  assign decoded_byte_o = out_result.decoded_byte;
  assign region_o       = out_result.region;
  assign frame_status_o = out_result.frame_status;
  assign payload_size_o = out_result.payload_size;
  assign name_length_o  = out_result.name_length;

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid && !advance |=> s_valid && $stable(s_item))
    else $error("input register lost a word while blocked");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !(advance && has_result))
    else $error("result register overwritten while stalled");

  a_verdict_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_verdict_o |-> decoded_byte_o == 8'd0 && region_o == RGN_HEADER)
    else $error("verdict carries data byte fields");

  a_byte_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_verdict_o |-> frame_status_o == ST_OK)
    else $error("decoded byte carries a status");

endmodule

### test/tb_cobs_frame_receiver_validator.sv
// Self-checking testbench for the COBS frame receiver and validator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfv_pkg::*;

  localparam int unsigned FrameCapacity = 512;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned MaxReported   = 10;

  localparam logic [CfgIndexW-1:0] CfgSpareLow  = 2'd2;
  localparam logic [CfgIndexW-1:0] CfgSpareHigh = 2'd3;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int unsigned {
    FK_GOOD,
    FK_CUT,
    FK_SHORT,
    FK_BAD_PAYLOAD,
    FK_BAD_NAME,
    FK_MISMATCH,
    FK_UNTERM,
    FK_OVERRUN,
    FK_NOISE
  } frame_kind_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  action_e              action_i    = ACT_BYTE;
  logic [7:0]           rx_byte_i   = 8'h00;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 is_verdict_o;
  logic [7:0]           decoded_byte_o;
  logic [1:0]           region_o;
  logic [3:0]           frame_status_o;
  logic [31:0]          payload_size_o;
  logic [31:0]          name_length_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = CfgMaxPayload;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;

  // Decoder state as the block should hold it.
  logic [15:0] lim_payload = MaxPayloadReset;
  logic [7:0]  lim_name    = MaxNameReset;
  bit          drop_on     = 1'b0;
  int unsigned enc_held    = 0;
  logic [7:0]  grp_left    = 8'h00;
  bit          zero_owed   = 1'b0;
  int unsigned dec_held    = 0;
  logic [63:0] hdr_bytes   = '0;
  bit          tail_zero   = 1'b0;

  result_t     due_words[$];
  result_t     seen_word;
  result_t     due_word;
  int unsigned error_count    = 0;
  int unsigned rx_words_fed   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  cobs_frame_receiver_validator #(
    .FRAME_CAPACITY(FrameCapacity)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_verdict_o  (is_verdict_o),
    .decoded_byte_o(decoded_byte_o),
    .region_o      (region_o),
    .frame_status_o(frame_status_o),
    .payload_size_o(payload_size_o),
    .name_length_o (name_length_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic void clear_frame_state();
    enc_held  = 0;
    grp_left  = 8'h00;
    zero_owed = 1'b0;
    dec_held  = 0;
    hdr_bytes = '0;
    tail_zero = 1'b0;
  endfunction

  function automatic result_t verdict_word(status_e st);
    result_t w;
    w = '0;
    w.is_verdict   = 1'b1;
    w.region       = RGN_HEADER;
    w.frame_status = st;
    w.payload_size = hdr_bytes[31:0];
    w.name_length  = hdr_bytes[63:32];
    return w;
  endfunction

  function automatic result_t decoded_word(logic [7:0] b);
    result_t w;
    w = '0;
    if (dec_held < HeaderLen) begin
      hdr_bytes[8*dec_held +: 8] = b;
      w.region = RGN_HEADER;
    end else if (64'(dec_held) < 64'(HeaderLen) + 64'(hdr_bytes[31:0])) begin
      w.region = RGN_PAYLOAD;
    end else begin
      w.region = RGN_NAME;
    end
    dec_held++;
    tail_zero      = (b == 8'h00);
    w.decoded_byte = b;
    w.frame_status = ST_OK;
    w.payload_size = hdr_bytes[31:0];
    w.name_length  = hdr_bytes[63:32];
    return w;
  endfunction

  function automatic status_e judge_frame();
    logic [63:0] psize;
    logic [63:0] nlen;
    psize = 64'(hdr_bytes[31:0]);
    nlen  = 64'(hdr_bytes[63:32]);
    if (grp_left != 8'h00) return ST_COBS_TRUNC;
    if (dec_held < HeaderLen) return ST_SHORT;
    if (psize == 0 || psize > 64'(lim_payload)) return ST_BAD_PAYLOAD;
    if (nlen == 0 || nlen > 64'(lim_name)) return ST_BAD_NAME;
    if (64'(dec_held) != 64'(HeaderLen) + psize + nlen) return ST_MISMATCH;
    if (!tail_zero) return ST_UNTERMINATED;
    return ST_OK;
  endfunction

  // Advance the decoder by one accepted word; returns 1 when it yields a result.
  function automatic bit decode_rx_word(input action_e act, input logic [7:0] b,
                                        output result_t res);
    bit produced;
    produced = 1'b0;
    res      = '0;
    if (act == ACT_OVERRUN) begin
      if (!drop_on && enc_held > 0) begin
        res      = verdict_word(ST_OVERRUN);
        produced = 1'b1;
      end
      clear_frame_state();
      drop_on = 1'b1;
    end else if (b == Delimiter) begin
      if (!drop_on && enc_held > 0) begin
        res      = verdict_word(judge_frame());
        produced = 1'b1;
      end
      clear_frame_state();
      drop_on = 1'b0;
    end else if (!drop_on) begin
      if (enc_held >= FrameCapacity) begin
        res      = verdict_word(ST_TOO_LARGE);
        produced = 1'b1;
        clear_frame_state();
        drop_on = 1'b1;
      end else begin
        enc_held++;
        if (grp_left == 8'h00) begin
          // the zero implied by the previous group only shows up now
          if (zero_owed) begin
            res      = decoded_word(8'h00);
            produced = 1'b1;
          end
          grp_left  = b - 8'd1;
          zero_owed = (b != CodeMax);
        end else begin
          res = decoded_word(b);
          grp_left--;
          produced = 1'b1;
        end
      end
    end
    return produced;
  endfunction

  function automatic byte_q_t cobs_pack(byte_q_t plain);
    byte_q_t coded;
    byte_q_t block;
    foreach (plain[i]) begin
      if (plain[i] == 8'h00) begin
        coded.push_back(8'(block.size() + 1));
        foreach (block[j]) coded.push_back(block[j]);
        block.delete();
      end else begin
        block.push_back(plain[i]);
        if (block.size() == 254) begin
          coded.push_back(CodeMax);
          foreach (block[j]) coded.push_back(block[j]);
          block.delete();
        end
      end
    end
    coded.push_back(8'(block.size() + 1));
    foreach (block[j]) coded.push_back(block[j]);
    return coded;
  endfunction

  function automatic byte_q_t frame_plain(int unsigned pay_len, int unsigned name_len,
                                          logic [31:0] pay_field, logic [31:0] name_field,
                                          bit terminated);
    byte_q_t plain;
    for (int i = 0; i < 4; i++) plain.push_back(pay_field[8*i +: 8]);
    for (int i = 0; i < 4; i++) plain.push_back(name_field[8*i +: 8]);
    repeat (pay_len) plain.push_back(8'($urandom));
    for (int unsigned i = 0; i < name_len; i++) begin
      if (terminated && i == name_len - 1) plain.push_back(8'h00);
      else plain.push_back(8'($urandom_range(1, 255)));
    end
    return plain;
  endfunction

  // Hold valid across back-to-back words; drop it only for an idle gap.
  task automatic send_word(input action_e act, input logic [7:0] b);
    result_t     res;
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (decode_rx_word(act, b, res)) due_words.push_back(res);
    rx_words_fed++;
  endtask

  task automatic send_bytes(byte_q_t q);
    foreach (q[i]) send_word(ACT_BYTE, q[i]);
  endtask

  task automatic send_frame(byte_q_t plain);
    send_bytes(cobs_pack(plain));
    send_word(ACT_BYTE, Delimiter);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_words.size() != 0);
    // words that yield nothing may still sit in the pipeline
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [15:0] pay_val, input logic [15:0] name_val);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgMaxPayload;
    cfg_wdata_i <= pay_val;
    @(posedge clk_i);
    lim_payload = pay_val;
    cfg_index_i <= CfgMaxName;
    cfg_wdata_i <= name_val;
    @(posedge clk_i);
    lim_name = name_val[7:0];
    // an index past the register list must change nothing
    cfg_index_i <= ($urandom_range(0, 1) != 0) ? CfgSpareLow : CfgSpareHigh;
    cfg_wdata_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_frame();
    byte_q_t     coded;
    byte_q_t     plain;
    int unsigned pay_cap;
    int unsigned name_cap;
    int unsigned pay_len;
    int unsigned name_len;
    int unsigned code;
    int unsigned cut_at;
    logic [31:0] bad_field;
    frame_kind_e kind;
    pay_cap  = (lim_payload == 0) ? 1 : lim_payload;
    name_cap = (lim_name == 0) ? 1 : lim_name;
    if ($urandom_range(0, 9) != 0) pay_cap = (pay_cap > 24) ? 24 : pay_cap;
    else pay_cap = (pay_cap > 100) ? 100 : pay_cap;
    if ($urandom_range(0, 9) != 0) name_cap = (name_cap > 12) ? 12 : name_cap;
    else name_cap = (name_cap > 64) ? 64 : name_cap;
    pay_len  = $urandom_range(1, pay_cap);
    name_len = $urandom_range(1, name_cap);
    kind = ($urandom_range(0, 1) != 0) ? FK_GOOD : frame_kind_e'($urandom_range(0, FK_NOISE));
    case (kind)
      FK_GOOD: begin
        send_frame(frame_plain(pay_len, name_len, pay_len, name_len, 1'b1));
      end
      FK_CUT: begin
        coded = cobs_pack(frame_plain(pay_len, name_len, pay_len, name_len, 1'b1));
        code  = $urandom_range(2, 255);
        coded.push_back(8'(code));
        repeat ($urandom_range(0, (code - 2 > 8) ? 8 : code - 2)) begin
          coded.push_back(8'($urandom_range(1, 255)));
        end
        send_bytes(coded);
        send_word(ACT_BYTE, Delimiter);
      end
      FK_SHORT: begin
        repeat ($urandom_range(0, HeaderLen - 1)) plain.push_back(8'($urandom));
        send_frame(plain);
      end
      FK_BAD_PAYLOAD: begin
        case ($urandom_range(0, 2))
          0:       bad_field = 32'd0;
          1:       bad_field = 32'(lim_payload) + 32'd1;
          default: bad_field = $urandom | 32'h0001_0000;
        endcase
        send_frame(frame_plain(pay_len, name_len, bad_field, name_len, 1'b1));
      end
      FK_BAD_NAME: begin
        case ($urandom_range(0, 2))
          0:       bad_field = 32'd0;
          1:       bad_field = 32'(lim_name) + 32'd1;
          default: bad_field = $urandom | 32'h0000_0100;
        endcase
        send_frame(frame_plain(pay_len, name_len, pay_len, bad_field, 1'b1));
      end
      FK_MISMATCH: begin
        send_frame(frame_plain(pay_len, name_len + $urandom_range(1, 3), pay_len, name_len,
                               1'b1));
      end
      FK_UNTERM: begin
        send_frame(frame_plain(pay_len, name_len, pay_len, name_len, 1'b0));
      end
      FK_OVERRUN: begin
        coded  = cobs_pack(frame_plain(pay_len, name_len, pay_len, name_len, 1'b1));
        cut_at = $urandom_range(0, coded.size());
        for (int unsigned i = 0; i < cut_at; i++) send_word(ACT_BYTE, coded[i]);
        send_word(ACT_OVERRUN, 8'($urandom));
        repeat ($urandom_range(0, 3)) send_word(ACT_BYTE, 8'($urandom_range(1, 255)));
        if ($urandom_range(0, 1) != 0) send_word(ACT_OVERRUN, 8'($urandom));
        send_word(ACT_BYTE, Delimiter);
      end
      default: begin
        repeat ($urandom_range(1, 6)) send_word(action_e'($urandom_range(0, 1)), 8'($urandom));
        send_word(ACT_BYTE, Delimiter);
      end
    endcase
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(ACT_BYTE, Delimiter);
    send_frame(frame_plain(1, 1, 32'd1, 32'd1, 1'b1));
    send_word(ACT_BYTE, 8'h02);
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, Delimiter);
    // group announced by the code byte never completes
    send_word(ACT_BYTE, 8'h05);
    send_word(ACT_BYTE, 8'h01);
    send_word(ACT_BYTE, Delimiter);
    send_word(ACT_BYTE, 8'h03);
    send_word(ACT_BYTE, 8'h11);
    send_word(ACT_OVERRUN, 8'h00);
    send_word(ACT_OVERRUN, 8'hFF);
    send_word(ACT_BYTE, 8'h05);
    send_word(ACT_BYTE, Delimiter);
    send_word(ACT_OVERRUN, 8'h5A);
    send_word(ACT_BYTE, Delimiter);
  endtask

  task automatic test_frame_overflow();
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    // the byte after a full frame's worth gets the too-large verdict
    repeat (FrameCapacity + 1) send_word(ACT_BYTE, 8'($urandom_range(1, 255)));
    repeat (3) send_word(ACT_BYTE, 8'($urandom_range(1, 255)));
    send_word(ACT_OVERRUN, 8'($urandom));
    send_word(ACT_BYTE, Delimiter);
  endtask

  task automatic test_limit_extremes();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    set_limits(16'd1, 16'hFF01);
    send_frame(frame_plain(1, 1, 32'd1, 32'd1, 1'b1));
    send_frame(frame_plain(2, 1, 32'd2, 32'd1, 1'b1));
    send_frame(frame_plain(1, 2, 32'd1, 32'd2, 1'b1));
    set_limits(16'd0, 16'd0);
    send_frame(frame_plain(1, 1, 32'd1, 32'd1, 1'b1));
    set_limits(16'hFFFF, 16'h00FF);
    send_frame(frame_plain(8, 20, 32'd8, 32'd20, 1'b1));
    send_frame(frame_plain(4, 3, 32'd65535, 32'd3, 1'b1));
    send_frame(frame_plain(4, 3, 32'd65536, 32'd3, 1'b1));
    send_frame(frame_plain(4, 3, 32'd4, 32'd256, 1'b1));
    send_frame(frame_plain(4, 3, 32'd4, 32'd3, 1'b0));
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input bit hold_once);
    int unsigned phase_end;
    logic [15:0] pay_val;
    pay_val = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 400));
    set_limits(pay_val, {8'($urandom), 8'($urandom_range(1, 255))});
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    phase_end      = rx_words_fed + 45;
    while (rx_words_fed < phase_end) begin
      send_random_frame();
      if (hold_once && rx_words_fed + 25 > phase_end) begin
        wait_drained();
        hold_once = 1'b0;
      end
    end
  endtask

  // Check each word taken from the output against the oldest one due.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_word.is_verdict   = is_verdict_o;
      seen_word.decoded_byte = decoded_byte_o;
      seen_word.region       = region_e'(region_o);
      seen_word.frame_status = status_e'(frame_status_o);
      seen_word.payload_size = payload_size_o;
      seen_word.name_length  = name_length_o;
      if (due_words.size() == 0) begin
        if (error_count < MaxReported) begin
          $display("%0t: unexpected word: verdict %0b byte %02h region %0d status %0d",
                   $realtime, is_verdict_o, decoded_byte_o, region_o, frame_status_o);
        end
        error_count++;
      end else begin
        due_word = due_words.pop_front();
        if (seen_word !== due_word) begin
          if (error_count < MaxReported) begin
            $display("%0t: mismatch (expected/actual) verdict %0b/%0b byte %02h/%02h",
                     $realtime, due_word.is_verdict, seen_word.is_verdict,
                     due_word.decoded_byte, seen_word.decoded_byte);
            $display("  region %0d/%0d status %0d/%0d psize %0d/%0d nlen %0d/%0d",
                     due_word.region, seen_word.region,
                     due_word.frame_status, seen_word.frame_status,
                     due_word.payload_size, seen_word.payload_size,
                     due_word.name_length, seen_word.name_length);
          end
          error_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_frame_overflow();
    test_limit_extremes();
    test_random_traffic(0, 0, 1'b0);
    test_random_traffic(63, 0, 1'b0);
    test_random_traffic(0, 63, 1'b1);
    test_random_traffic(36, 36, 1'b1);
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
hdl/cfv_pkg.sv
hdl/cfv_in_reg.sv
hdl/cfv_decoder.sv
hdl/cfv_out_reg.sv
hdl/cobs_frame_receiver_validator.sv
test/tb_cobs_frame_receiver_validator.sv
